// ----- rtl/v2d_pkg.sv -----
// Package for the 2D vector arithmetic unit: beat types, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
package v2d_pkg;

  typedef enum logic [2:0] {
    CMD_DOT   = 3'd0,
    CMD_CROSS = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_MUL   = 3'd4,
    CMD_DIV   = 3'd5,
    CMD_MAG   = 3'd6,
    CMD_NORM  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  localparam int unsigned FieldW = 32;
  localparam int unsigned StatW  = 2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [FieldW-1:0] a_x;
    logic signed [FieldW-1:0] a_y;
    logic signed [FieldW-1:0] b_x;
    logic signed [FieldW-1:0] b_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [FieldW-1:0] result_x;
    logic signed [FieldW-1:0] result_y;
    logic [StatW-1:0]         status;
  } out_beat_t;

endpackage

// ----- rtl/v2d_sqrt_stage.sv -----
// One registered stage of the restoring integer square root (one root bit per stage).
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module v2d_sqrt_stage #(
  parameter int unsigned RadW = 128,
  parameter int unsigned Step = 0,
  parameter int unsigned PayW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RadW-1:0] rem_i,
  input  logic [RadW-1:0] root_i,
  input  logic [PayW-1:0] pay_i,
  output logic [RadW-1:0] rem_o,
  output logic [RadW-1:0] root_o,
  output logic [PayW-1:0] pay_o
);
  localparam int unsigned BitPos = RadW - 2 - 2 * Step;
  logic [RadW-1:0] bit_w, trial_w, rem_d, root_d;

  always_comb begin
    bit_w   = '0;
    bit_w[BitPos] = 1'b1;
    trial_w = root_i + bit_w;
    if (rem_i >= trial_w) begin
      rem_d  = rem_i - trial_w;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      pay_o  <= pay_i;
    end
  end
endmodule

// ----- rtl/v2d_div_stage.sv -----
// One registered stage of a restoring unsigned divider, one quotient bit per stage.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module v2d_div_stage #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 64,
  parameter int unsigned PayW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW:0]   rem_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [PayW-1:0] pay_i,
  output logic [DenW:0]   rem_o,
  output logic [NumW-1:0] num_o,
  output logic [DenW-1:0] den_o,
  output logic [PayW-1:0] pay_o
);
  logic [DenW+1:0] shf_w;
  logic [DenW+1:0] dif_w;
  logic [DenW:0]   rem_d;
  logic [NumW-1:0] num_d;

  always_comb begin
    shf_w = {rem_i, num_i[NumW-1]};
    dif_w = shf_w - {2'b00, den_i};
    num_d = num_i << 1;
    if (!dif_w[DenW+1]) begin
      rem_d    = dif_w[DenW:0];
      num_d[0] = 1'b1;
    end else begin
      rem_d    = shf_w[DenW:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      num_o <= num_d;
      den_o <= den_i;
      pay_o <= pay_i;
    end
  end
endmodule

// ----- rtl/vector2d_arithmetic_unit.sv -----
// Top level of the 2D vector arithmetic unit: front stage, root pipeline,
// divider pipelines, output stage. Uses v2d_pkg, v2d_sqrt_stage, v2d_div_stage.
//
// Usage: an input beat (command, A, B) enters on in_valid_i/in_stall_o and one
// result beat (result_x, result_y, status) leaves on out_valid_o/out_stall_i.
// Every command takes the same path, so results leave in input order.
// Throughput: one beat per cycle while the output is not stalled. Stages in
// order: input register, sum-of-squares register, DATA_WIDTH root stages (one
// root bit each, the last bit resolved in divider setup), divider setup stage,
// DATA_WIDTH+FRAC_BITS divider stages (one quotient bit each) and the output
// register.
// The whole pipeline advances together; when out_stall_i is high and the last
// stage holds a beat, every stage holds, bubbles included, and in_stall_o
// rises, so no beat is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module vector2d_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  v2d_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output v2d_pkg::out_beat_t  out_data_o
);
  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned PW    = 2 * DW;          // product width
  localparam int unsigned RadW  = 2 * DW + 2;      // sum of squares, even
  localparam int unsigned RSteps = RadW / 2;
  localparam int unsigned NumW  = DW + FRAC_BITS;  // |a| << F
  localparam int unsigned DenW  = DW + 1;          // |b| or root
  localparam int unsigned QSteps = NumW;
  localparam int unsigned NStages = 1 + RSteps + 1 + QSteps + 1;
  localparam int unsigned PayW = 3 + 2 + 2 * DW + DenW * 2 + 2 * (PW + 2);

  // stage valid chain, all advance together
  logic [NStages-1:0] vld_q;
  logic               adv;
  assign adv        = !(vld_q[NStages-1] && out_stall_i) ;
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // ---------------- stage 0: sign extend, products
  logic [2:0]           cmd_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q <= in_data_i.command;
      ax_q  <= DW'(in_data_i.a_x);
      ay_q  <= DW'(in_data_i.a_y);
      bx_q  <= DW'(in_data_i.b_x);
      by_q  <= DW'(in_data_i.b_y);
    end
  end
  // registered products (second front stage folded into payload of root stage 0)
  logic signed [PW-1:0] pxx_w, pyy_w, pxy_w, pyx_w;
  assign pxx_w = PW'(ax_q) * PW'(bx_q);
  assign pyy_w = PW'(ay_q) * PW'(by_q);
  assign pxy_w = PW'(ax_q) * PW'(by_q);
  assign pyx_w = PW'(ay_q) * PW'(bx_q);
  logic [PW-1:0] sx_w, sy_w;
  assign sx_w = PW'(ax_q) * PW'(ax_q);
  assign sy_w = PW'(ay_q) * PW'(ay_q);

  // payload into the root chain: cmd, products (dot/cross combined here)
  // fields: cmd, signs of b, ax, ay, den_x, den_y, r1, r2
  logic signed [PW+1:0] r1_w, r2_w;
  logic [DenW-1:0]      dnx_w, dny_w;
  always_comb begin
    r1_w  = '0;
    r2_w  = '0;
    dnx_w = DenW'(bx_q[DW-1] ? -{1'b1, bx_q} : {1'b0, bx_q});
    dny_w = DenW'(by_q[DW-1] ? -{1'b1, by_q} : {1'b0, by_q});
    case (v2d_pkg::cmd_e'(cmd_q))
      v2d_pkg::CMD_DOT:   r1_w = (PW+2)'(pxx_w) + (PW+2)'(pyy_w);
      v2d_pkg::CMD_CROSS: r1_w = (PW+2)'(pxy_w) - (PW+2)'(pyx_w);
      v2d_pkg::CMD_ADD: begin
        r1_w = (PW+2)'(ax_q) + (PW+2)'(bx_q);
        r2_w = (PW+2)'(ay_q) + (PW+2)'(by_q);
      end
      v2d_pkg::CMD_SUB: begin
        r1_w = (PW+2)'(ax_q) - (PW+2)'(bx_q);
        r2_w = (PW+2)'(ay_q) - (PW+2)'(by_q);
      end
      v2d_pkg::CMD_MUL: begin
        r1_w = (PW+2)'(pxx_w);
        r2_w = (PW+2)'(pyy_w);
      end
      default: ;
    endcase
  end

  logic [PayW-1:0] rpay_in;
  assign rpay_in = {cmd_q, bx_q[DW-1], by_q[DW-1], ax_q, ay_q, dnx_w, dny_w, r1_w, r2_w};

  logic [RadW-1:0] rem_c [RSteps+1];
  logic [RadW-1:0] root_c [RSteps+1];
  logic [PayW-1:0] rpay_c [RSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_c[0]  <= RadW'(sx_w) + RadW'(sy_w);
      root_c[0] <= '0;
      rpay_c[0] <= rpay_in;
    end
  end

  for (genvar g = 0; g < RSteps - 1; g++) begin : g_root
    v2d_sqrt_stage #(.RadW(RadW), .Step(g), .PayW(PayW)) u_rt (
      .clk_i (clk_i), .en_i(adv),
      .rem_i (rem_c[g]), .root_i(root_c[g]), .pay_i(rpay_c[g]),
      .rem_o (rem_c[g+1]), .root_o(root_c[g+1]), .pay_o(rpay_c[g+1])
    );
  end
  // last root step folded with divider setup
  localparam int unsigned LR = RSteps - 1;
  logic [RadW-1:0] lbit_w, ltrial_w, root_f;
  always_comb begin
    lbit_w    = RadW'(1);
    ltrial_w  = root_c[LR] + lbit_w;
    root_f    = (rem_c[LR] >= ltrial_w) ? ((root_c[LR] >> 1) + lbit_w) : (root_c[LR] >> 1);
  end

  // unpack root payload
  logic [2:0]           p_cmd;
  logic [1:0]           p_fl;
  logic signed [DW-1:0] p_ax, p_ay;
  logic [DenW-1:0]      p_dx, p_dy;
  logic signed [PW+1:0] p_r1, p_r2;
  assign {p_cmd, p_fl, p_ax, p_ay, p_dx, p_dy, p_r1, p_r2} = rpay_c[LR];

  // magnitude fits DenW bits: sqrt(2^(2DW-1)) < 2^DW
  logic [DenW-1:0] mag_w;
  assign mag_w = DenW'(root_f);
  logic            isdiv, isnorm;
  logic [DenW-1:0] den_x, den_y;
  logic            dz_w;
  logic signed [PW+1:0] r1_s;
  always_comb begin
    isdiv  = (p_cmd == v2d_pkg::CMD_DIV);
    isnorm = (p_cmd == v2d_pkg::CMD_NORM);
    den_x  = isnorm ? mag_w : p_dx;
    den_y  = isnorm ? mag_w : p_dy;
    dz_w   = (isdiv && (p_dx == '0 || p_dy == '0)) || (isnorm && mag_w == '0);
    r1_s   = (p_cmd == v2d_pkg::CMD_MAG) ? (PW+2)'(mag_w) : p_r1;
  end
  logic [DenW-1:0] nax_w, nay_w;
  assign nax_w = DenW'(p_ax[DW-1] ? -{1'b1, p_ax} : {1'b0, p_ax});
  assign nay_w = DenW'(p_ay[DW-1] ? -{1'b1, p_ay} : {1'b0, p_ay});
  // result signs: a xor b for div, a for normalize
  logic negx_w, negy_w;
  assign negx_w = p_ax[DW-1] ^ (isdiv & p_fl[1]);
  assign negy_w = p_ay[DW-1] ^ (isdiv & p_fl[0]);

  // divider chains; x payload = cmd, dz, negx, negy, r1; y payload = r2
  localparam int unsigned DPayW = 3 + 1 + 2 + (PW + 2);
  localparam int unsigned YPayW = PW + 2;
  logic [DenW:0]    xr_c [QSteps+1], yr_c [QSteps+1];
  logic [NumW-1:0]  xn_c [QSteps+1], yn_c [QSteps+1];
  logic [DenW-1:0]  xd_c [QSteps+1], yd_c [QSteps+1];
  logic [DPayW-1:0] dp_c [QSteps+1];
  logic [YPayW-1:0] yp_c [QSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xr_c[0] <= '0;
      yr_c[0] <= '0;
      xn_c[0] <= NumW'(nax_w) << FRAC_BITS;
      yn_c[0] <= NumW'(nay_w) << FRAC_BITS;
      xd_c[0] <= den_x;
      yd_c[0] <= den_y;
      dp_c[0] <= {p_cmd, dz_w, negx_w, negy_w, r1_s};
      yp_c[0] <= p_r2;
    end
  end
  for (genvar g = 0; g < QSteps; g++) begin : g_div
    v2d_div_stage #(.NumW(NumW), .DenW(DenW), .PayW(DPayW)) u_dx (
      .clk_i(clk_i), .en_i(adv), .rem_i(xr_c[g]), .num_i(xn_c[g]), .den_i(xd_c[g]),
      .pay_i(dp_c[g]), .rem_o(xr_c[g+1]), .num_o(xn_c[g+1]), .den_o(xd_c[g+1]),
      .pay_o(dp_c[g+1])
    );
    v2d_div_stage #(.NumW(NumW), .DenW(DenW), .PayW(YPayW)) u_dy (
      .clk_i(clk_i), .en_i(adv), .rem_i(yr_c[g]), .num_i(yn_c[g]), .den_i(yd_c[g]),
      .pay_i(yp_c[g]), .rem_o(yr_c[g+1]), .num_o(yn_c[g+1]), .den_o(yd_c[g+1]),
      .pay_o(yp_c[g+1])
    );
  end

  // final stage: shift, sign, saturate
  logic [2:0]           f_cmd;
  logic                 f_dz, f_nx, f_ny;
  logic signed [PW+1:0] f_r1, f_r2;
  assign {f_cmd, f_dz, f_nx, f_ny, f_r1} = dp_c[QSteps];
  assign f_r2 = yp_c[QSteps];

  localparam int unsigned WW = PW + 2;
  localparam logic signed [WW-1:0] MaxV = WW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [WW-1:0] MinV = -MaxV - WW'(1);

  logic signed [WW-1:0] vx, vy, qx, qy;
  logic                 scal, sat_w;
  logic signed [DW-1:0] ox, oy;
  always_comb begin
    qx = f_nx ? -WW'(xn_c[QSteps]) : WW'(xn_c[QSteps]);
    qy = f_ny ? -WW'(yn_c[QSteps]) : WW'(yn_c[QSteps]);
    scal = 1'b0;
    vx = f_r1;
    vy = f_r2;
    case (v2d_pkg::cmd_e'(f_cmd))
      v2d_pkg::CMD_DOT, v2d_pkg::CMD_CROSS: begin
        vx = f_r1 >>> FRAC_BITS;
        vy = '0;
        scal = 1'b1;
      end
      v2d_pkg::CMD_MUL: begin
        vx = f_r1 >>> FRAC_BITS;
        vy = f_r2 >>> FRAC_BITS;
      end
      v2d_pkg::CMD_MAG: begin
        vy = '0;
        scal = 1'b1;
      end
      v2d_pkg::CMD_DIV, v2d_pkg::CMD_NORM: begin
        vx = qx;
        vy = qy;
      end
      default: ;
    endcase
    sat_w = 1'b0;
    if (vx > MaxV) begin ox = DW'(MaxV); sat_w = 1'b1; end
    else if (vx < MinV) begin ox = DW'(MinV); sat_w = 1'b1; end
    else ox = DW'(vx);
    if (vy > MaxV) begin oy = DW'(MaxV); sat_w = 1'b1; end
    else if (vy < MinV) begin oy = DW'(MinV); sat_w = 1'b1; end
    else oy = DW'(vy);
    if (scal) oy = '0;
  end

  v2d_pkg::out_beat_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.result_x <= f_dz ? '0 : v2d_pkg::FieldW'(ox);
      out_q.result_y <= f_dz ? '0 : v2d_pkg::FieldW'(oy);
      out_q.status   <= f_dz ? v2d_pkg::ST_DZ : (sat_w ? v2d_pkg::ST_SAT : v2d_pkg::ST_OK);
    end
  end
  assign out_data_o = out_q;
endmodule

// ----- rtl/v2d_checker.sv -----
// Port checker for the 2D vector arithmetic unit, bound to the top level.
// Uses v2d_pkg.
`timescale 1ns / 1ps
module v2d_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input v2d_pkg::out_beat_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled beat changed");
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == v2d_pkg::ST_DZ |->
      out_data_o.result_x == '0 && out_data_o.result_y == '0)
    else $error("nonzero result on divide by zero");
endmodule

bind vector2d_arithmetic_unit v2d_checker u_v2d_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
